[sv/jsu_pkg.sv]
// Shared types and constants for the JSON string unescaper.
// No dependencies; the front, queue, back and top modules import this package.
package jsu_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_TEXT     = 3'd1,
    MODE_ESC      = 3'd2,
    MODE_HEX      = 3'd3,
    MODE_PAIR_BS  = 3'd4,
    MODE_PAIR_U   = 3'd5,
    MODE_PAIR_HEX = 3'd6
  } mode_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_OK       = 3'd1,
    ST_BAD_ESC  = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_BAD_SURR = 3'd4,
    ST_CTRL     = 3'd5,
    ST_NO_QUOTE = 3'd6
  } status_e;

  // Job kinds passed from front to back
  typedef enum logic [1:0] {
    JOB_RAW    = 2'd0,  // one byte as is
    JOB_CP     = 2'd1,  // code point, UTF-8 encoded
    JOB_STATUS = 2'd2   // status only
  } job_kind_e;

  localparam int unsigned CpW    = 21;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    job_kind_e        kind;
    logic [CpW-1:0]   data;
    status_e          status;
  } job_t;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // Surrogate ranges and UTF-8 bounds
  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [CpW-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CpW-1:0] UTF8_MAX1 = 21'h7F;
  localparam logic [CpW-1:0] UTF8_MAX2 = 21'h7FF;
  localparam logic [CpW-1:0] UTF8_MAX3 = 21'hFFFF;

endpackage

[sv/jsu_in_if.sv]
// Input request channel: one string-body byte per request.
// Depends on nothing.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_string;

  modport source (output valid, output in_byte, output new_string, input ready);
  modport sink   (input valid, input in_byte, input new_string, output ready);
endinterface

[sv/jsu_out_if.sv]
// Output request channel: one decoded byte or status per request.
// Depends on nothing.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input status,
                  input last, output ready);
endinterface

[sv/jsu_front.sv]
// Front end: escape/hex/surrogate parser, one input byte per cycle while the job queue is not full.
// Depends on jsu_pkg and jsu_in_if; pushes jobs into jsu_queue.
module jsu_front import jsu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  jsu_in_if.sink  req_i,
  input  logic    q_full_i,
  output logic    push_o,
  output job_t    push_job_o
);

  mode_e       mode_q, mode_d, mode_cur;
  logic [1:0]  cnt_q, cnt_d, cnt_cur;
  logic [15:0] acc_q, acc_d, acc_cur, acc_nxt;
  logic [15:0] hs_q, hs_d, hs_cur;
  logic [4:0]  hv;
  logic [7:0]  ch;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30:8'h39]}) r = {1'b0, c[3:0]};
    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

  assign req_i.ready = !q_full_i;
  assign ch          = req_i.in_byte;
  assign hv          = hex_val(ch);
  assign acc_nxt     = {acc_cur[11:0], hv[3:0]};

  always_comb begin
    if (req_i.new_string) begin
      mode_cur = MODE_TEXT;
      cnt_cur  = '0;
      acc_cur  = '0;
      hs_cur   = '0;
    end else begin
      mode_cur = mode_q;
      cnt_cur  = cnt_q;
      acc_cur  = acc_q;
      hs_cur   = hs_q;
    end
  end

  always_comb begin
    mode_d            = mode_q;
    cnt_d             = cnt_q;
    acc_d             = acc_q;
    hs_d              = hs_q;
    push_o            = 1'b0;
    push_job_o.kind   = JOB_RAW;
    push_job_o.data   = {{(CpW-8){1'b0}}, ch};
    push_job_o.status = ST_RUN;

    if (req_i.valid && req_i.ready) begin
      mode_d = mode_cur;
      cnt_d  = cnt_cur;
      acc_d  = acc_cur;
      hs_d   = hs_cur;
      case (mode_cur)
        MODE_TEXT: begin
          if (ch == CH_NUL) begin
            push_o = 1'b1; push_job_o.kind = JOB_STATUS; push_job_o.status = ST_NO_QUOTE;
            mode_d = MODE_IDLE;
          end else if (ch == CH_QUOTE) begin
            push_o = 1'b1; push_job_o.kind = JOB_STATUS; push_job_o.status = ST_OK;
            mode_d = MODE_IDLE;
          end else if (ch == CH_BSLASH) begin
            mode_d = MODE_ESC;
          end else if (ch < CH_SPACE) begin
            push_o = 1'b1; push_job_o.kind = JOB_STATUS; push_job_o.status = ST_CTRL;
            mode_d = MODE_IDLE;
          end else begin
            push_o = 1'b1;
          end
        end
        MODE_ESC: begin
          mode_d = MODE_TEXT;
          push_o = 1'b1;
          case (ch)
            CH_QUOTE, CH_BSLASH, CH_SLASH: ;
            CH_LC_B: push_job_o.data = {{(CpW-8){1'b0}}, CTL_BS};
            CH_LC_F: push_job_o.data = {{(CpW-8){1'b0}}, CTL_FF};
            CH_LC_N: push_job_o.data = {{(CpW-8){1'b0}}, CTL_LF};
            CH_LC_R: push_job_o.data = {{(CpW-8){1'b0}}, CTL_CR};
            CH_LC_T: push_job_o.data = {{(CpW-8){1'b0}}, CTL_HT};
            CH_LC_U: begin
              push_o = 1'b0;
              mode_d = MODE_HEX;
              cnt_d  = '0;
              acc_d  = '0;
            end
            default: begin
              push_job_o.kind   = JOB_STATUS;
              push_job_o.status = ST_BAD_ESC;
              mode_d            = MODE_IDLE;
            end
          endcase
        end
        MODE_HEX, MODE_PAIR_HEX: begin
          if (hv[4]) begin
            push_o = 1'b1; push_job_o.kind = JOB_STATUS; push_job_o.status = ST_BAD_HEX;
            mode_d = MODE_IDLE;
          end else begin
            acc_d = acc_nxt;
            if (cnt_cur != 2'd3) begin
              cnt_d = cnt_cur + 2'd1;
            end else begin
              cnt_d = '0;
              if (mode_cur == MODE_HEX) begin
                if (acc_nxt >= HI_SURR_MIN && acc_nxt <= HI_SURR_MAX) begin
                  hs_d   = acc_nxt;
                  mode_d = MODE_PAIR_BS;
                end else begin
                  mode_d = MODE_TEXT;
                  push_o = 1'b1;
                  push_job_o.kind = JOB_CP;
                  push_job_o.data = {{(CpW-16){1'b0}}, acc_nxt};
                end
              end else if (acc_nxt < LO_SURR_MIN || acc_nxt > LO_SURR_MAX) begin
                push_o = 1'b1; push_job_o.kind = JOB_STATUS;
                push_job_o.status = ST_BAD_SURR;
                mode_d = MODE_IDLE;
              end else begin
                // (hi - D800) and (lo - DC00) are the low ten bits of each
                mode_d = MODE_TEXT;
                push_o = 1'b1;
                push_job_o.kind = JOB_CP;
                push_job_o.data = {1'b0, hs_cur[9:0], acc_nxt[9:0]} + SUPP_BASE;
              end
            end
          end
        end
        MODE_PAIR_BS: begin
          if (ch != CH_BSLASH) begin
            push_o = 1'b1; push_job_o.kind = JOB_STATUS; push_job_o.status = ST_BAD_SURR;
            mode_d = MODE_IDLE;
          end else begin
            mode_d = MODE_PAIR_U;
          end
        end
        MODE_PAIR_U: begin
          if (ch != CH_LC_U) begin
            push_o = 1'b1; push_job_o.kind = JOB_STATUS; push_job_o.status = ST_BAD_SURR;
            mode_d = MODE_IDLE;
          end else begin
            mode_d = MODE_PAIR_HEX;
            cnt_d  = '0;
            acc_d  = '0;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
      acc_q  <= '0;
      hs_q   <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hs_q   <= hs_d;
    end
  end

endmodule

[sv/jsu_queue.sv]
// Small job FIFO between parser front end and UTF-8 back end.
// Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  output logic head_valid_o,
  output job_t head_job_o,
  input  logic pop_i
);

  job_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAw:0]     count_q;

  assign full_o       = (count_q == (QAw+1)'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[sv/jsu_back.sv]
// Back end: expands jobs into 1..4 result requests, registered output.
// Depends on jsu_pkg and jsu_out_if.
module jsu_back import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_job_i,
  output logic      pop_o,
  jsu_out_if.source rsp_o
);

  logic [1:0]     k_q;
  logic [1:0]     nlast;
  logic [1:0]     seg_sel;
  logic [CpW-1:0] cp;
  logic [7:0]     lead, cont, piece;
  logic           load;

  logic           vld_q;
  logic [7:0]     byte_q;
  logic           bv_q;
  status_e        st_q;
  logic           last_q;

  assign cp = head_job_i.data;

  always_comb begin
    if (cp <= UTF8_MAX1)      nlast = 2'd0;
    else if (cp <= UTF8_MAX2) nlast = 2'd1;
    else if (cp <= UTF8_MAX3) nlast = 2'd2;
    else                      nlast = 2'd3;
  end

  always_comb begin
    case (nlast)
      2'd0:    lead = cp[7:0];
      2'd1:    lead = {3'b110, cp[10:6]};
      2'd2:    lead = {4'b1110, cp[15:12]};
      default: lead = {5'b11110, cp[20:18]};
    endcase
  end

  // continuation byte k carries six bits from position 6*(nlast-k)
  assign seg_sel = nlast - k_q;
  always_comb begin
    case (seg_sel)
      2'd0:    cont = {2'b10, cp[5:0]};
      2'd1:    cont = {2'b10, cp[11:6]};
      default: cont = {2'b10, cp[17:12]};
    endcase
  end

  assign piece = (k_q == 2'd0) ? lead : cont;
  assign load  = head_valid_i && (!vld_q || rsp_o.ready);

  always_comb begin
    pop_o = 1'b0;
    if (load) begin
      if (head_job_i.kind != JOB_CP || k_q == nlast) pop_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      case (head_job_i.kind)
        JOB_CP: begin
          byte_q <= piece;
          bv_q   <= 1'b1;
          st_q   <= ST_RUN;
          last_q <= (k_q == nlast);
        end
        JOB_STATUS: begin
          byte_q <= '0;
          bv_q   <= 1'b0;
          st_q   <= head_job_i.status;
          last_q <= 1'b1;
        end
        default: begin
          byte_q <= cp[7:0];
          bv_q   <= 1'b1;
          st_q   <= ST_RUN;
          last_q <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      k_q   <= '0;
    end else begin
      if (load)              vld_q <= 1'b1;
      else if (rsp_o.ready)  vld_q <= 1'b0;
      if (pop_o)             k_q <= '0;
      else if (load)         k_q <= k_q + 2'd1;
    end
  end

  assign rsp_o.valid      = vld_q;
  assign rsp_o.out_byte   = byte_q;
  assign rsp_o.byte_valid = bv_q;
  assign rsp_o.status     = st_q;
  assign rsp_o.last       = last_q;

endmodule

[sv/json_string_unescape_utf8_top.sv]
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  req_i   | in  | req_i.valid/.ready   | in_byte[7:0], new_string
//  rsp_o   | out | rsp_o.valid/.ready   | out_byte[7:0], byte_valid, status[2:0], last
//
// One input byte is taken per cycle while the 4-entry job queue has room.
// Each byte yields at most one job; the back end turns a job into one result
// per cycle while rsp_o is ready, so a code point yields 1..4 results (its UTF-8 length).
// An accepted byte's job is registered in the queue, then its result in the output register.
// rst_ni clears parser mode, queue pointers and the output valid; no sweep.
// Input and output stall independently; the queue decouples them.
module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    req_i,
  jsu_out_if.source rsp_o
);

  logic q_full;
  logic push;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  // Parser: classifies input bytes into raw byte, code point or status jobs
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  // Decoupling queue
  jsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .pop_i        (pop)
  );

  // UTF-8 encoder and output register
  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

endmodule
